@@ sv/mlp_sigmoid_softmax_inference_core_defines.svh @@
// Assertion macros shared by the inference core RTL.
`ifndef MLP_SIGMOID_SOFTMAX_INFERENCE_CORE_DEFINES_SVH
`define MLP_SIGMOID_SOFTMAX_INFERENCE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define MSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MSS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/mss_pkg.sv @@
// Types, constants and helpers for the MLP inference core.
package mss_pkg;

    localparam int MAX_WIDTH         = 64;
    localparam int MAX_WEIGHT_LAYERS = 3;
    localparam int VALUE_BITS        = 16;

    localparam int IDX_BITS      = $clog2(MAX_WIDTH);
    localparam int CNT_BITS      = IDX_BITS + 1;
    localparam int LAYER_BITS    = 2;
    localparam int WT_DEPTH      = MAX_WEIGHT_LAYERS * (2 ** (2 * IDX_BITS));
    localparam int WT_ADDR_BITS  = $clog2(WT_DEPTH);
    localparam int ACT_DEPTH     = 2 * (2 ** IDX_BITS);
    localparam int ACT_ADDR_BITS = IDX_BITS + 1;
    localparam int EXP_DEPTH     = 2 ** IDX_BITS;
    localparam int EXP_BITS      = 32;
    localparam int SUM_BITS      = 40;
    localparam int ACC_BITS      = 40;
    localparam int FRAC_SHIFT    = 12;
    localparam int DIV_NUM_BITS  = 48;
    localparam int DIV_DEN_BITS  = 40;
    localparam int DIV_CNT_BITS  = $clog2(DIV_NUM_BITS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;

    localparam int LOG2E_Q14 = 23637;
    localparam int EXP_C1    = 43024;
    localparam int EXP_C2    = 22512;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIDDEN_ONE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIDDEN_TWO   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUTPUT_WIDTH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_COUNT  = 3'd4;

    // Item kinds
    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [1:0]                   layer_index;
        logic [5:0]                   node_index;
        logic [5:0]                   source_index;
        logic signed [VALUE_BITS-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  class_index;
        logic [15:0] probability;
        logic        last_class;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic                     wt_we;
        logic [WT_ADDR_BITS-1:0]  wt_raddr;
        logic                     act_we;
        logic                     act_from_item;
        logic [ACT_ADDR_BITS-1:0] act_waddr;
        logic [ACT_ADDR_BITS-1:0] act_raddr;
        logic                     mac_issue;
        logic                     mac_first;
        logic                     exp_go;
        logic                     sig_mode;
        logic                     exp_we;
        logic [IDX_BITS-1:0]      exp_addr;
        logic                     sum_clear;
        logic                     div_sig;
        logic                     div_prob;
        logic                     emit;
        logic                     emit_last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic mac_busy;
        logic exp_done;
        logic div_done;
    } t_dp_status;

    // A width of zero counts as one; larger than the array saturates.
    function automatic logic [CNT_BITS-1:0] clamp_width(input logic [CFG_DATA_BITS-1:0] w);
        logic [CNT_BITS-1:0] r;
        if (w == '0) begin
            r = CNT_BITS'(1);
        end else if (CFG_DATA_BITS'(w) > CFG_DATA_BITS'(MAX_WIDTH)) begin
            r = CNT_BITS'(MAX_WIDTH);
        end else begin
            r = CNT_BITS'(w);
        end
        return r;
    endfunction

endpackage

@@ sv/mss_ram.sv @@
// Generic simple dual-port RAM with registered read.
module mss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mss_div.sv @@
// Restoring divider, one quotient bit per cycle.
module mss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [mss_pkg::DIV_NUM_BITS-1:0]  i_num,
    input  logic [mss_pkg::DIV_DEN_BITS-1:0]  i_den,
    output logic                              o_done,
    output logic [mss_pkg::DIV_NUM_BITS-1:0]  o_quot
);

    logic [mss_pkg::DIV_DEN_BITS:0]     r_rem;
    logic [mss_pkg::DIV_NUM_BITS-1:0]   r_num;
    logic [mss_pkg::DIV_DEN_BITS-1:0]   r_den;
    logic [mss_pkg::DIV_NUM_BITS-1:0]   r_quot;
    logic [mss_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic [mss_pkg::DIV_DEN_BITS:0]     w_shift;
    logic                               w_fit;

    // Shift in the next numerator bit and trial-subtract
    assign w_shift = {r_rem[mss_pkg::DIV_DEN_BITS-1:0], r_num[mss_pkg::DIV_NUM_BITS-1]};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mss_pkg::DIV_CNT_BITS'(mss_pkg::DIV_NUM_BITS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? (w_shift - {1'b0, r_den}) : w_shift;
            r_num  <= {r_num[mss_pkg::DIV_NUM_BITS-2:0], 1'b0};
            r_quot <= {r_quot[mss_pkg::DIV_NUM_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ sv/mss_dp.sv @@
// Datapath: stores, multiply-accumulate, exp pipeline, divider, result register.
module mss_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mss_pkg::t_in_item     i_item,
    input  mss_pkg::t_dp_cmd      i_cmd,
    output mss_pkg::t_dp_status   o_status,
    output mss_pkg::t_out_item    o_result,
    output logic                  o_result_strobe
);

    localparam int VB = mss_pkg::VALUE_BITS;
    localparam int AB = mss_pkg::ACC_BITS;
    localparam logic signed [AB-1:0] Q_MAX = AB'((1 << (VB - 1)) - 1);
    localparam logic signed [AB-1:0] Q_MIN = -Q_MAX - AB'(1);
    localparam logic signed [VB-1:0] P_MAX = VB'((1 << (VB - 1)) - 1);
    localparam logic signed [VB-1:0] P_MIN = -P_MAX - VB'(1);

    logic signed [VB-1:0]               w_wt;
    logic signed [VB-1:0]               w_act;
    logic [mss_pkg::EXP_BITS-1:0]       w_exp_rd;
    logic [VB-1:0]                      w_act_wdata;

    logic                               r_v1, r_f1, r_v2, r_f2;
    logic signed [2*VB-1:0]             r_prod;
    logic signed [AB-1:0]               r_acc;
    logic signed [AB-1:0]               w_q;
    logic signed [VB-1:0]               w_pre;
    logic signed [VB-1:0]               w_neg;

    logic [4:0]                         r_ev;
    logic signed [VB-1:0]               r_arg;
    logic signed [32:0]                 w_t;
    logic signed [33:0]                 w_u;
    logic [30:0]                        r_u;
    logic [15:0]                        r_f;
    logic [4:0]                         r_n;
    logic [30:0]                        r_p1;
    logic [16:0]                        w_c;
    logic [32:0]                        r_p2;
    logic [4:0]                         r_n2;
    logic [17:0]                        w_m;
    logic [mss_pkg::EXP_BITS-1:0]       r_e;
    logic [mss_pkg::SUM_BITS-1:0]       r_sum;

    logic [32:0]                        w_d;
    logic [mss_pkg::DIV_NUM_BITS-1:0]   w_num;
    logic [mss_pkg::DIV_DEN_BITS-1:0]   w_den;
    logic                               w_div_done;
    logic [mss_pkg::DIV_NUM_BITS-1:0]   w_quot;
    logic [15:0]                        w_prob;

    mss_pkg::t_out_item                 r_out;
    logic                               r_strobe;

    // Stores
    mss_ram #(.WIDTH(VB), .DEPTH(mss_pkg::WT_DEPTH)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wt_we),
        .i_waddr (mss_pkg::WT_ADDR_BITS'({i_item.layer_index, i_item.node_index,
                                          i_item.source_index})),
        .i_wdata (i_item.value),
        .i_raddr (i_cmd.wt_raddr),
        .o_rdata (w_wt)
    );

    assign w_act_wdata = i_cmd.act_from_item ? i_item.value : VB'(w_quot);

    mss_ram #(.WIDTH(VB), .DEPTH(mss_pkg::ACT_DEPTH)) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.act_we),
        .i_waddr (i_cmd.act_waddr),
        .i_wdata (w_act_wdata),
        .i_raddr (i_cmd.act_raddr),
        .o_rdata (w_act)
    );

    mss_ram #(.WIDTH(mss_pkg::EXP_BITS), .DEPTH(mss_pkg::EXP_DEPTH)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exp_we),
        .i_waddr (i_cmd.exp_addr),
        .i_wdata (r_e),
        .i_raddr (i_cmd.exp_addr),
        .o_rdata (w_exp_rd)
    );

    // MAC pipeline control: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ev <= '0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
            r_ev <= {r_ev[3:0], i_cmd.exp_go};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1   <= i_cmd.mac_first;
        r_f2   <= r_f1;
        r_prod <= w_wt * w_act;
        if (r_v2) begin
            r_acc <= (r_f2 ? AB'(0) : r_acc)
                   + {{(AB - 2 * VB){r_prod[2*VB-1]}}, r_prod};
        end
    end

    // Scale by 2^-12 with floor, then saturate
    assign w_q = r_acc >>> mss_pkg::FRAC_SHIFT;
    always_comb begin
        if (w_q > Q_MAX) begin
            w_pre = P_MAX;
        end else if (w_q < Q_MIN) begin
            w_pre = P_MIN;
        end else begin
            w_pre = VB'(w_q);
        end
    end
    assign w_neg = (w_pre == P_MIN) ? P_MAX : -w_pre;

    // Exp pipeline: log2 scaling, fraction polynomial, power-of-two shift
    assign w_t = r_arg * $signed(17'(mss_pkg::LOG2E_Q14));
    assign w_u = 34'(w_t) + 34'(12 * (1 << 26));
    assign w_c = 17'(mss_pkg::EXP_C1) + 17'(r_p1[30:16]);
    assign w_m = 18'(65536) + 18'(r_p2[32:16]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exp_go) begin
            r_arg <= i_cmd.sig_mode ? w_neg : w_pre;
        end
        r_u  <= w_u[30:0];
        r_f  <= r_u[25:10];
        r_n  <= r_u[30:26];
        r_p1 <= {15'd0, r_u[25:10]} * 31'(mss_pkg::EXP_C2);
        r_p2 <= {17'd0, r_f} * {16'd0, w_c};
        r_n2 <= r_n;
        if (r_n2 < 5'd8) begin
            r_e <= 32'(w_m) >> (5'd8 - r_n2);
        end else begin
            r_e <= 32'(w_m) << (r_n2 - 5'd8);
        end
    end

    // Exponent sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.sum_clear) begin
            r_sum <= '0;
        end else if (i_cmd.exp_we) begin
            r_sum <= r_sum + mss_pkg::SUM_BITS'(r_e);
        end
    end

    // Shared divider: sigmoid reciprocal or probability
    assign w_d = 33'(1 << 20) + 33'(r_e);
    always_comb begin
        if (i_cmd.div_sig) begin
            w_num = mss_pkg::DIV_NUM_BITS'(64'd1 << 32) + mss_pkg::DIV_NUM_BITS'(w_d >> 1);
            w_den = mss_pkg::DIV_DEN_BITS'(w_d);
        end else begin
            w_num = {w_exp_rd, 16'd0};
            w_den = r_sum;
        end
    end

    mss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_sig | i_cmd.div_prob),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_prob = (|w_quot[mss_pkg::DIV_NUM_BITS-1:16]) ? 16'hFFFF : w_quot[15:0];

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.class_index <= 6'(i_cmd.exp_addr);
            r_out.probability <= w_prob;
            r_out.last_class  <= i_cmd.emit_last;
        end
    end

    assign o_status.mac_busy = r_v1 | r_v2;
    assign o_status.exp_done = r_ev[4];
    assign o_status.div_done = w_div_done;
    assign o_result          = r_out;
    assign o_result_strobe   = r_strobe;

endmodule

@@ sv/mss_ctrl.sv @@
// Controller: configuration registers and the layer/node/source sequencer.
`include "mlp_sigmoid_softmax_inference_core_defines.svh"
module mss_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  mss_pkg::t_in_item                    i_item,
    input  logic                                 i_cfg_valid,
    input  logic [mss_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  mss_pkg::t_dp_status                  i_status,
    output mss_pkg::t_dp_cmd                     o_cmd
);

    localparam int IB = mss_pkg::IDX_BITS;
    localparam int CB = mss_pkg::CNT_BITS;

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_MAC       = 8'b0000_0010,
        S_DRAIN     = 8'b0000_0100,
        S_EXP       = 8'b0000_1000,
        S_DIV       = 8'b0001_0000,
        S_OUT_RD    = 8'b0010_0000,
        S_OUT_START = 8'b0100_0000,
        S_OUT_DIV   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic [mss_pkg::CFG_DATA_BITS-1:0] r_cfg_in, r_cfg_h1, r_cfg_h2, r_cfg_out;
    logic [1:0]                        r_cfg_layers;
    logic [1:0]                        r_layer, n_layer;
    logic [IB-1:0]                     r_node, n_node;
    logic [IB-1:0]                     r_src, n_src;
    logic                              r_bank, n_bank;

    logic [1:0]    w_layers;
    logic [1:0]    w_last_layer;
    logic          w_is_last;
    logic [CB-1:0] w_iw, w_h1, w_h2, w_ow;
    logic [CB-1:0] w_k, w_n;
    logic          w_feat_ok;
    logic          w_pass_go;
    logic          w_node_end;
    mss_pkg::t_dp_cmd cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_in     <= 7'd64;
            r_cfg_h1     <= 7'd64;
            r_cfg_h2     <= 7'd64;
            r_cfg_out    <= 7'd3;
            r_cfg_layers <= 2'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mss_pkg::CFG_INPUT_WIDTH:  r_cfg_in     <= i_cfg_data;
                mss_pkg::CFG_HIDDEN_ONE:   r_cfg_h1     <= i_cfg_data;
                mss_pkg::CFG_HIDDEN_TWO:   r_cfg_h2     <= i_cfg_data;
                mss_pkg::CFG_OUTPUT_WIDTH: r_cfg_out    <= i_cfg_data;
                mss_pkg::CFG_LAYER_COUNT:  r_cfg_layers <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes
    assign w_iw = mss_pkg::clamp_width(r_cfg_in);
    assign w_h1 = mss_pkg::clamp_width(r_cfg_h1);
    assign w_h2 = mss_pkg::clamp_width(r_cfg_h2);
    assign w_ow = mss_pkg::clamp_width(r_cfg_out);
    always_comb begin
        if (r_cfg_layers == 2'd0) begin
            w_layers = 2'd1;
        end else if (r_cfg_layers > 2'(mss_pkg::MAX_WEIGHT_LAYERS)) begin
            w_layers = 2'(mss_pkg::MAX_WEIGHT_LAYERS);
        end else begin
            w_layers = r_cfg_layers;
        end
    end
    assign w_last_layer = w_layers - 2'd1;
    assign w_is_last    = (r_layer == w_last_layer);

    // Fan-in of the current layer and node count of its destination
    always_comb begin
        if (r_layer == 2'd0) begin
            w_k = w_iw;
        end else if (r_layer == 2'd1) begin
            w_k = w_h1;
        end else begin
            w_k = w_h2;
        end
        if (w_is_last) begin
            w_n = w_ow;
        end else if (r_layer == 2'd0) begin
            w_n = w_h1;
        end else begin
            w_n = w_h2;
        end
    end

    assign w_feat_ok  = (CB'(i_item.source_index) < w_iw);
    assign w_pass_go  = i_item.kind == mss_pkg::KIND_FEATURE && w_feat_ok
                     && (CB'(i_item.source_index) == w_iw - CB'(1));
    assign w_node_end = (CB'(r_node) == w_n - CB'(1));

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_layer = r_layer;
        n_node  = r_node;
        n_src   = r_src;
        n_bank  = r_bank;
        cmd           = '0;
        cmd.wt_raddr  = mss_pkg::WT_ADDR_BITS'({r_layer, r_node, r_src});
        cmd.act_raddr = {r_bank, r_src};
        cmd.act_waddr = {~r_bank, r_node};
        cmd.exp_addr  = r_node;
        cmd.emit_last = (CB'(r_node) == w_ow - CB'(1));
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_item.kind == mss_pkg::KIND_WEIGHT) begin
                        cmd.wt_we = (32'(i_item.layer_index) < mss_pkg::MAX_WEIGHT_LAYERS);
                    end else if (w_feat_ok) begin
                        cmd.act_we        = 1'b1;
                        cmd.act_from_item = 1'b1;
                        cmd.act_waddr     = {1'b0, IB'(i_item.source_index)};
                    end
                    if (w_pass_go) begin
                        cmd.sum_clear = 1'b1;
                        n_layer = '0;
                        n_node  = '0;
                        n_src   = '0;
                        n_bank  = 1'b0;
                        n_state = S_MAC;
                    end
                end
            end
            S_MAC: begin
                cmd.mac_issue = 1'b1;
                cmd.mac_first = (r_src == '0);
                if (CB'(r_src) == w_k - CB'(1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_src = r_src + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_status.mac_busy) begin
                    cmd.exp_go   = 1'b1;
                    cmd.sig_mode = !w_is_last;
                    n_state      = S_EXP;
                end
            end
            S_EXP: begin
                if (i_status.exp_done) begin
                    if (w_is_last) begin
                        cmd.exp_we = 1'b1;
                        n_src = '0;
                        if (w_node_end) begin
                            n_node  = '0;
                            n_state = S_OUT_RD;
                        end else begin
                            n_node  = r_node + 1'b1;
                            n_state = S_MAC;
                        end
                    end else begin
                        cmd.div_sig = 1'b1;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    cmd.act_we = 1'b1;
                    n_src      = '0;
                    n_state    = S_MAC;
                    if (w_node_end) begin
                        n_node  = '0;
                        n_layer = r_layer + 1'b1;
                        n_bank  = ~r_bank;
                    end else begin
                        n_node = r_node + 1'b1;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT_START;
            end
            S_OUT_START: begin
                cmd.div_prob = 1'b1;
                n_state      = S_OUT_DIV;
            end
            S_OUT_DIV: begin
                if (i_status.div_done) begin
                    cmd.emit = 1'b1;
                    if (cmd.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_node  = r_node + 1'b1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_layer <= '0;
            r_node  <= '0;
            r_src   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_layer <= n_layer;
            r_node  <= n_node;
            r_src   <= n_src;
            r_bank  <= n_bank;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_cmd  = cmd;

    // Checks
    `MSS_ASSERT_NEXT(a_pass_start, i_clk, i_rst_n, (r_state == S_IDLE) && i_start && w_pass_go, r_state == S_MAC)
    `MSS_ASSERT_IMPL(a_exp_only_last, i_clk, i_rst_n, cmd.exp_we, w_is_last)
    `MSS_ASSERT_IMPL(a_emit_on_quot, i_clk, i_rst_n, cmd.emit, i_status.div_done && (r_state == S_OUT_DIV))

endmodule

@@ sv/mlp_sigmoid_softmax_inference_core.sv @@
// Top level of the MLP inference core: sigmoid hidden layers, softmax output.
//
// Items enter on i_item, transferred when start is high and busy is low.
// Kind 0 writes one weight; kind 1 writes one input feature.
// The feature at position input_width-1 starts a forward pass; busy stays
// high until the last class has been emitted.
// Per destination node a layer runs on the one shared multiply-accumulate
// unit; on a hidden layer the bit-serial divider, also used for the output
// probabilities, forms the sigmoid. The output phase then divides once per
// class. Each result appears on o_result for one cycle with o_result_strobe
// high; the receiver takes every result and cannot stall the block.
// Registers are to be written over i_cfg_valid / i_cfg_index / i_cfg_data
// only while idle; the block itself does not enforce this. o_cfg_ready is
// always high. Reset restores the register defaults and clears the
// exponent sum; weight and activation stores are undefined until written.
module mlp_sigmoid_softmax_inference_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  mss_pkg::t_in_item                    i_item,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mss_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output mss_pkg::t_out_item                   o_result,
    output logic                                 o_result_strobe
);

    mss_pkg::t_dp_cmd    w_cmd;
    mss_pkg::t_dp_status w_status;

    mss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    mss_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

endmodule

@@ sim/mlp_sigmoid_softmax_inference_core_tb.sv @@
// Self-checking testbench for the MLP inference core: directed table, then random phases.
`timescale 1ns / 1ps

module mlp_sigmoid_softmax_inference_core_tb;
    import mss_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 150;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    t_out_item o_result;
    logic      o_result_strobe;

    mlp_sigmoid_softmax_inference_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_result(o_result), .o_result_strobe(o_result_strobe)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the block: registers, stores
    logic [6:0]  reg_mirror [5];
    shortint     weights [MAX_WEIGHT_LAYERS][MAX_WIDTH][MAX_WIDTH];
    shortint     acts [2][MAX_WIDTH];
    int unsigned exps [MAX_WIDTH];
    t_out_item   expected_probs [$];
    int          errors = 0;
    int          cycles = 0;
    int          burst_left = 0;

    function automatic int eff_width(logic [6:0] w);
        if (w == 0) return 1;
        if (w > MAX_WIDTH) return MAX_WIDTH;
        return int'(w);
    endfunction

    function automatic int eff_layers();
        logic [1:0] c;
        c = reg_mirror[CFG_LAYER_COUNT][1:0];
        if (c == 0) return 1;
        return int'(c);
    endfunction

    // Layer sizes: input, hidden one, hidden two..., output
    function automatic int layer_size(int i, int layers);
        if (i == 0) return eff_width(reg_mirror[CFG_INPUT_WIDTH]);
        if (i == layers) return eff_width(reg_mirror[CFG_OUTPUT_WIDTH]);
        if (i == 1) return eff_width(reg_mirror[CFG_HIDDEN_ONE]);
        return eff_width(reg_mirror[CFG_HIDDEN_TWO]);
    endfunction

    function automatic longint clamp_q(longint x);
        if (x > 32767) return 32767;
        if (x < -32768) return -32768;
        return x;
    endfunction

    // Q8.24 sum to Q4.12, floor then saturate
    function automatic longint narrow_sum(longint acc);
        return clamp_q(acc >>> FRAC_SHIFT);
    endfunction

    // Polynomial exp, Q4.12 in, Q12.20 out
    function automatic int unsigned q_exp(longint arg);
        longint t, u, f, m, r;
        int n;
        t = clamp_q(arg) * 23637;
        u = t + (longint'(12) <<< 26);
        n = int'(u >>> 26);
        f = (u & 64'h3FF_FFFF) >>> 10;
        m = 65536 + ((f * (43024 + ((22512 * f) >>> 16))) >>> 16);
        if (n < 8) r = m >>> (8 - n);
        else r = m <<< (n - 8);
        return r[31:0];
    endfunction

    function automatic shortint q_sigmoid(longint arg);
        longint nx, d, r;
        nx = -clamp_q(arg);
        if (nx > 32767) nx = 32767;
        d = (longint'(1) <<< 20) + longint'(q_exp(nx));
        r = ((longint'(1) <<< 32) + (d >>> 1)) / d;
        return shortint'(r);
    endfunction

    // Whole forward pass; appends one probability per class
    task automatic forward_pass(ref t_out_item res [$]);
        int layers, src, dst, k, n, nout;
        longint acc, total, p;
        t_out_item r;
        layers = eff_layers();
        src = 0;
        for (int l = 0; l < layers; l++) begin
            k = layer_size(l, layers);
            n = layer_size(l + 1, layers);
            dst = src ^ 1;
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int s = 0; s < k; s++)
                    acc += longint'(weights[l][j][s]) * longint'(acts[src][s]);
                if (l == layers - 1) exps[j] = q_exp(narrow_sum(acc));
                else acts[dst][j] = q_sigmoid(narrow_sum(acc));
            end
            src = dst;
        end
        nout = layer_size(layers, layers);
        total = 0;
        for (int j = 0; j < nout; j++) total += longint'(exps[j]);
        total &= (longint'(1) <<< 40) - 1;
        for (int j = 0; j < nout; j++) begin
            p = 65535;
            if (total != 0) begin
                p = (longint'(exps[j]) <<< 16) / total;
                if (p > 65535) p = 65535;
            end
            r.class_index = j[5:0];
            r.probability = p[15:0];
            r.last_class  = (j == nout - 1);
            res = {res, r};
        end
    endtask

    // Update the mirror for one accepted item and queue its probabilities
    task automatic apply_item(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item res [$];
        int iw;
        if (it.kind == KIND_WEIGHT) begin
            if (it.layer_index < MAX_WEIGHT_LAYERS)
                weights[it.layer_index][it.node_index][it.source_index] = it.value;
        end else begin
            iw = eff_width(reg_mirror[CFG_INPUT_WIDTH]);
            if (it.source_index < iw) begin
                acts[0][it.source_index] = it.value;
                if (it.source_index == iw - 1) begin
                    forward_pass(res);
                    if (typed) expected_probs = {expected_probs, typed_res};
                    else foreach (res[i]) expected_probs = {expected_probs, res[i]};
                end
            end
        end
    endtask

    // One item transfer, with bursty pacing ahead of it
    task automatic send(t_in_item it, bit typed = 0, t_out_item typed_res = '0);
        bit ok;
        int g;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (g != 0) begin
                start <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
        burst_left--;
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        apply_item(it, typed, typed_res);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [6:0] val);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        reg_mirror[idx] = val;
        @(posedge i_clk);
    endtask

    // Lower start, then wait for every probability plus the block's tail
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_probs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(logic kind, int layer, int node, int src,
                                           logic [15:0] val);
        t_in_item it;
        it.kind         = kind;
        it.layer_index  = layer[1:0];
        it.node_index   = node[5:0];
        it.source_index = src[5:0];
        it.value        = val;
        return it;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // Configure, load every weight in use, sweep the features, then random items
    task automatic run_phase(logic [6:0] iw, logic [6:0] h1, logic [6:0] h2,
                             logic [6:0] ow, logic [6:0] lc, int n_rand, bit pressure);
        int layers, w;
        write_reg(CFG_INPUT_WIDTH, iw);
        write_reg(CFG_HIDDEN_ONE, h1);
        write_reg(CFG_HIDDEN_TWO, h2);
        write_reg(CFG_OUTPUT_WIDTH, ow);
        write_reg(CFG_LAYER_COUNT, lc);
        layers = eff_layers();
        for (int l = 0; l < layers; l++)
            for (int j = 0; j < layer_size(l + 1, layers); j++)
                for (int s = 0; s < layer_size(l, layers); s++)
                    send(make_item(KIND_WEIGHT, l, j, s, pick_value()));
        w = layer_size(0, layers);
        for (int s = 0; s < w; s++)
            send(make_item(KIND_FEATURE, 0, $urandom_range(0, 63), s, pick_value()));
        for (int i = 0; i < n_rand; i++) begin
            if (pressure && i == n_rand / 2) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (expected_probs.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 4)
                send(make_item(KIND_WEIGHT, $urandom_range(0, 3), $urandom_range(0, 63),
                               $urandom_range(0, 63), pick_value()));
            else if ($urandom_range(0, 9) < 3)
                send(make_item(KIND_FEATURE, $urandom_range(0, 3), $urandom_range(0, 63),
                               w - 1, pick_value()));
            else
                send(make_item(KIND_FEATURE, $urandom_range(0, 3), $urandom_range(0, 63),
                               $urandom_range(0, 63), pick_value()));
        end
        drain();
    endtask

    // Directed rows: single class, so every probability saturates
    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_row;

    localparam t_out_item ONLY_CLASS = '{class_index: 6'd0, probability: 16'hFFFF,
                                         last_class: 1'b1};

    t_row rows [11];

    // Compare each result strobe against the oldest expectation
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_result_strobe) begin
            if (expected_probs.size() == 0) begin
                $display("%0t: unexpected result class %0d prob %0d last %0b", $time,
                         o_result.class_index, o_result.probability, o_result.last_class);
                errors++;
            end else begin
                want = expected_probs.pop_front();
                if (o_result.class_index !== want.class_index) begin
                    $display("%0t: class_index expected %0d actual %0d", $time,
                             want.class_index, o_result.class_index);
                    errors++;
                end
                if (o_result.probability !== want.probability) begin
                    $display("%0t: probability expected %0d actual %0d", $time,
                             want.probability, o_result.probability);
                    errors++;
                end
                if (o_result.last_class !== want.last_class) begin
                    $display("%0t: last_class expected %0b actual %0b", $time,
                             want.last_class, o_result.last_class);
                    errors++;
                end
            end
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** mlp_sigmoid_softmax_inference_core: FAILED **");
            $finish;
        end
    end

    initial begin
        reg_mirror[CFG_INPUT_WIDTH]  = 7'd64;
        reg_mirror[CFG_HIDDEN_ONE]   = 7'd64;
        reg_mirror[CFG_HIDDEN_TWO]   = 7'd64;
        reg_mirror[CFG_OUTPUT_WIDTH] = 7'd3;
        reg_mirror[CFG_LAYER_COUNT]  = 7'd3;

        rows[0]  = '{make_item(KIND_WEIGHT, 0, 0, 0, 16'h7FFF), 0, '0};
        rows[1]  = '{make_item(KIND_FEATURE, 0, 0, 0, 16'h8000), 1, ONLY_CLASS};
        rows[2]  = '{make_item(KIND_FEATURE, 0, 0, 0, 16'h7FFF), 1, ONLY_CLASS};
        rows[3]  = '{make_item(KIND_WEIGHT, 0, 0, 0, 16'h8000), 0, '0};
        rows[4]  = '{make_item(KIND_FEATURE, 3, 63, 0, 16'h0000), 1, ONLY_CLASS};
        // layer index past the array: ignored
        rows[5]  = '{make_item(KIND_WEIGHT, 3, 63, 63, 16'h5A5A), 0, '0};
        rows[6]  = '{make_item(KIND_WEIGHT, 2, 63, 63, 16'h1234), 0, '0};
        // features past the input width: ignored
        rows[7]  = '{make_item(KIND_FEATURE, 0, 0, 63, 16'h0005), 0, '0};
        rows[8]  = '{make_item(KIND_FEATURE, 0, 0, 1, 16'hFFFF), 0, '0};
        rows[9]  = '{make_item(KIND_WEIGHT, 1, 0, 0, 16'h0001), 0, '0};
        rows[10] = '{make_item(KIND_FEATURE, 0, 0, 0, 16'h1000), 1, ONLY_CLASS};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero input width and zero layer count: one feature straight to one class
        write_reg(CFG_INPUT_WIDTH, 7'd0);
        write_reg(CFG_OUTPUT_WIDTH, 7'd1);
        write_reg(CFG_LAYER_COUNT, 7'd0);
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
        drain();

        run_phase(7'd3, 7'd4, 7'd0, 7'd5, 7'd3, 30, 1);
        run_phase(7'd0, 7'd127, 7'd127, 7'd127, 7'd0, 20, 0);
        run_phase(7'd5, 7'd3, 7'd2, 7'd4, 7'd2, 20, 0);
        run_phase(7'd2, 7'd2, 7'd3, 7'd2, 7'd3, 10, 0);

        if (errors == 0) begin
            $display("** mlp_sigmoid_softmax_inference_core: PASSED **");
        end else begin
            $display("** mlp_sigmoid_softmax_inference_core: FAILED **");
        end
        $finish;
    end

endmodule
